// File: design/igba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// igba_pkg
// Shared types and constants for the greedy IoU box assignment block.
// ----------------------------------------------------------------------------
package igba_pkg;

  localparam int SLOTS           = 32;
  localparam int IDX_W           = 5;
  localparam int DEF_MAX_DETS    = 32;
  localparam int DEF_MAX_TRACKS  = 32;
  localparam logic [15:0] THRESH_RESET = 16'd19661;

  typedef enum logic [1:0] {
    CMD_LOAD_DET = 2'd0,
    CMD_LOAD_TRK = 2'd1,
    CMD_RUN      = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EMPTY,
    ST_IOU_RD,
    ST_IOU_A,
    ST_IOU_B,
    ST_IOU_DIV,
    ST_IOU_WR,
    ST_SCAN_RD,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

// File: design/igba_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// igba_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module igba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: design/iou_greedy_box_assignment_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iou_greedy_box_assignment_top
// Greedy IoU association of loaded detection boxes to track boxes.
// ----------------------------------------------------------------------------
// Usage: present an item on cmd and the box ports with start high while busy
// is low. Loads (detection or track) give no result; loads beyond capacity
// are dropped. A run command raises busy, computes the IoU of every
// detection/track pair into a matrix RAM with a 50-step restoring divider,
// then does greedy passes: each pass scans all pairs through the RAM read
// port, one pair a cycle, and assigns the best free one if it reaches
// match_threshold. Results follow one per cycle on result_valid, one per
// detection in order, last marked; an empty run gives one result with
// has_entry low. Both lists empty after a run. The receiver cannot stall;
// results are shown for exactly one cycle. Reset clears the counts, the
// sequencer and sets the threshold to about 0.3; box stores are undefined
// until loaded. cfg_we writes match_threshold; the user must do so only while
// idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module iou_greedy_box_assignment_top #(
  parameter int MAX_DETS   = igba_pkg::DEF_MAX_DETS,
  parameter int MAX_TRACKS = igba_pkg::DEF_MAX_TRACKS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output      logic                       busy,
  input  wire logic [1:0]                 cmd,
  input  wire logic [15:0]                box_left,
  input  wire logic [15:0]                box_top,
  input  wire logic [15:0]                box_width,
  input  wire logic [15:0]                box_height,
  input  wire logic                       cfg_we,
  input  wire logic [15:0]                cfg_wdata,
  output      logic                       result_valid,
  output      logic [igba_pkg::IDX_W-1:0] det_index,
  output      logic                       is_matched,
  output      logic [igba_pkg::IDX_W-1:0] track_index,
  output      logic                       has_entry,
  output      logic                       last
);
  import igba_pkg::*;

  localparam int DCAP = (MAX_DETS < SLOTS) ? MAX_DETS : SLOTS;
  localparam int TCAP = (MAX_TRACKS < SLOTS) ? MAX_TRACKS : SLOTS;

  state_t state, state_next;

  logic [15:0]      match_threshold;
  logic [5:0]       det_count, track_count;
  logic [5:0]       nd, nt;
  logic [IDX_W-1:0] di, ti;
  logic [IDX_W-1:0] bi, bj;
  logic [15:0]      best;
  logic             found;
  logic [SLOTS-1:0] det_done, track_taken;
  logic [IDX_W-1:0] det_trk [SLOTS];
  logic             rd_valid;
  logic [IDX_W-1:0] rd_d, rd_t;

  // box RAMs
  logic accept;
  logic det_we, trk_we;
  logic [IDX_W-1:0] det_ra, trk_ra;
  logic [63:0] det_rd, trk_rd, box_in;
  assign accept = start && !busy;
  assign box_in = {box_height, box_width, box_top, box_left};
  assign det_we = accept && cmd == CMD_LOAD_DET && det_count < 6'(DCAP);
  assign trk_we = accept && cmd == CMD_LOAD_TRK && track_count < 6'(TCAP);
  assign det_ra = di;
  assign trk_ra = ti;

  igba_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_det (
    .clk, .we(det_we), .waddr(det_count[IDX_W-1:0]), .wdata(box_in),
    .raddr(det_ra), .rdata(det_rd));
  igba_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_trk (
    .clk, .we(trk_we), .waddr(track_count[IDX_W-1:0]), .wdata(box_in),
    .raddr(trk_ra), .rdata(trk_rd));

  // IoU matrix RAM
  logic        ov_we;
  logic [9:0]  ov_ra;
  logic [15:0] ov_rd, iou;
  assign ov_we = state == ST_IOU_WR;
  assign ov_ra = {di, ti};
  igba_ram #(.WIDTH(16), .DEPTH(SLOTS*SLOTS)) u_ov (
    .clk, .we(ov_we), .waddr({di, ti}), .wdata(iou),
    .raddr(ov_ra), .rdata(ov_rd));

  // IoU datapath
  logic [16:0] iw, ih;
  logic [33:0] inter;
  logic [32:0] area_a, area_b;
  logic [33:0] uni;
  logic [49:0] rem;
  logic [49:0] quo;
  logic [5:0]  dstep;
  logic [16:0] x1, y1, x2, y2;
  logic [16:0] ar, br, ab, bb;

  always_comb begin
    x1 = {1'b0, (det_rd[15:0] > trk_rd[15:0]) ? det_rd[15:0] : trk_rd[15:0]};
    y1 = {1'b0, (det_rd[31:16] > trk_rd[31:16]) ? det_rd[31:16] : trk_rd[31:16]};
    ar = {1'b0, det_rd[15:0]} + {1'b0, det_rd[47:32]};
    br = {1'b0, trk_rd[15:0]} + {1'b0, trk_rd[47:32]};
    ab = {1'b0, det_rd[31:16]} + {1'b0, det_rd[63:48]};
    bb = {1'b0, trk_rd[31:16]} + {1'b0, trk_rd[63:48]};
    x2 = (ar < br) ? ar : br;
    y2 = (ab < bb) ? ab : bb;
  end

  // restoring division of inter<<16 by union, one quotient bit a step
  logic [50:0] rem_sh;
  logic [50:0] rem_sub;
  assign rem_sh  = {rem, quo[49]};
  assign rem_sub = rem_sh - {17'd0, uni};
  assign iou = (uni == 34'd0) ? 16'd0 :
               ((quo[49:16] != 34'd0) ? 16'hFFFF : quo[15:0]);

  always_ff @(posedge clk) begin
    case (state)
      ST_IOU_A: begin
        iw <= (x2 > x1) ? x2 - x1 : 17'd0;
        ih <= (y2 > y1) ? y2 - y1 : 17'd0;
        area_a <= {1'b0, 32'(det_rd[47:32]) * 32'(det_rd[63:48])};
        area_b <= {1'b0, 32'(trk_rd[47:32]) * 32'(trk_rd[63:48])};
      end
      ST_IOU_B: begin
        inter <= iw * ih;
        dstep <= 6'd0;
        rem   <= 50'd0;
      end
      ST_IOU_DIV: begin
        if (dstep == 6'd0) begin
          uni <= {1'b0, area_a} + {1'b0, area_b} - inter;
          quo <= {inter[33:0], 16'd0};
          dstep <= 6'd1;
        end else begin
          if (!rem_sub[50]) begin
            rem <= rem_sub[49:0];
            quo <= {quo[48:0], 1'b1};
          end else begin
            rem <= rem_sh[49:0];
            quo <= {quo[48:0], 1'b0};
          end
          dstep <= dstep + 6'd1;
        end
      end
      default: ;
    endcase
  end

  logic div_done;
  assign div_done = dstep == 6'd50;

  logic ti_end, di_end;
  assign ti_end = 6'(ti) + 6'd1 == nt;
  assign di_end = 6'(di) + 6'd1 == nd;

  // sequencer indices and greedy bookkeeping
  logic scan_hit;
  assign scan_hit = rd_valid && !det_done[rd_d] && !track_taken[rd_t] &&
                    (!found || ov_rd > best);

  // the last read of a pass lands in the decide cycle and is folded in here
  logic             dec_found;
  logic [15:0]      dec_best;
  logic [IDX_W-1:0] dec_bi, dec_bj;
  assign dec_found = found || scan_hit;
  assign dec_best  = scan_hit ? ov_rd : best;
  assign dec_bi    = scan_hit ? rd_d : bi;
  assign dec_bj    = scan_hit ? rd_t : bj;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:
        if (accept && cmd == CMD_RUN) begin
          if (det_count == 6'd0) state_next = ST_EMPTY;
          else if (track_count == 6'd0) state_next = ST_EMIT;
          else state_next = ST_IOU_RD;
        end
      ST_EMPTY:   state_next = ST_IDLE;
      ST_IOU_RD:  state_next = ST_IOU_A;
      ST_IOU_A:   state_next = ST_IOU_B;
      ST_IOU_B:   state_next = ST_IOU_DIV;
      ST_IOU_DIV: if (div_done) state_next = ST_IOU_WR;
      ST_IOU_WR:  state_next = (ti_end && di_end) ? ST_SCAN_RD : ST_IOU_RD;
      ST_SCAN_RD: state_next = ST_SCAN;
      ST_SCAN:    if (ti_end && di_end) state_next = ST_DECIDE;
      ST_DECIDE:
        if (!dec_found || dec_best < match_threshold) state_next = ST_EMIT;
        else state_next = ST_SCAN_RD;
      ST_EMIT:    if (di_end) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy         = state != ST_IDLE;
    result_valid = state == ST_EMPTY || state == ST_EMIT;
    det_index    = (state == ST_EMIT) ? di : '0;
    is_matched   = (state == ST_EMIT) && det_done[di];
    track_index  = (state == ST_EMIT && det_done[di]) ? det_trk[di] : '0;
    has_entry    = state == ST_EMIT;
    last         = state == ST_EMPTY || (state == ST_EMIT && di_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      match_threshold <= THRESH_RESET;
      det_count <= '0;
      track_count <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) match_threshold <= cfg_wdata;
      if (det_we) det_count <= det_count + 6'd1;
      if (trk_we) track_count <= track_count + 6'd1;
      if (accept && cmd == CMD_RUN) begin
        det_count <= '0;
        track_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= 1'b0;
    case (state)
      ST_IDLE: begin
        di <= '0;
        ti <= '0;
        nd <= det_count;
        nt <= track_count;
        det_done <= '0;
        track_taken <= '0;
      end
      ST_IOU_WR: begin
        if (ti_end) begin
          ti <= '0;
          di <= di_end ? '0 : di + 1'b1;
        end else begin
          ti <= ti + 1'b1;
        end
        found <= 1'b0;
      end
      ST_SCAN_RD, ST_SCAN: begin
        rd_valid <= 1'b1;
        rd_d <= di;
        rd_t <= ti;
        if (state == ST_SCAN && scan_hit) begin
          found <= 1'b1;
          best <= ov_rd;
          bi <= rd_d;
          bj <= rd_t;
        end
        if (ti_end) begin
          ti <= '0;
          di <= di_end ? '0 : di + 1'b1;
        end else begin
          ti <= ti + 1'b1;
        end
      end
      ST_DECIDE: begin
        if (dec_found && dec_best >= match_threshold) begin
          det_done[dec_bi] <= 1'b1;
          det_trk[dec_bi] <= dec_bj;
          track_taken[dec_bj] <= 1'b1;
        end
        found <= 1'b0;
        di <= '0;
        ti <= '0;
      end
      ST_EMIT: di <= di + 1'b1;
      default: ;
    endcase
  end

  property p_one_result_when_empty;
    @(posedge clk) disable iff (rst) state == ST_EMPTY |=> state == ST_IDLE;
  endproperty
  a_empty: assert property (p_one_result_when_empty) else $error("empty run");

  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    last |-> result_valid) else $error("last without result");

  a_busy_run: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_RUN) |=> busy) else $error("run not busy");

  a_counts_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_RUN) |=> det_count == 6'd0 && track_count == 6'd0)
    else $error("counts not cleared");
endmodule
`default_nettype wire
